/* sv/dap_shader_pkg.sv */
package dap_shader_pkg;

  // Field widths fixed by the pixel format
  localparam int VecW  = 16;
  localparam int ChanW = 8;
  localparam int RegW  = 16;
  localparam int CfgIdxW = 3;

  // Arithmetic sizes
  localparam int SqrtSteps = 32;   // one root bit per cell
  localparam int DivSteps  = 13;   // quotient bits for a Q.12 cosine up to 4096
  localparam int ProdW = 64;       // |dir|^2 * |norm|^2
  localparam int RemW  = 35;
  localparam int RootW = 32;
  localparam int NumW  = 45;
  localparam int CosW  = 13;
  localparam logic [CosW-1:0] OneQ12 = 13'd4096;
  localparam logic [ChanW-1:0] ChanMax = 8'd255;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegAmbient = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLight   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBgRed   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBgGreen = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBgBlue  = 3'd4;

  typedef struct packed {
    logic                   hit;
    logic signed [VecW-1:0] dir_x;
    logic signed [VecW-1:0] dir_y;
    logic signed [VecW-1:0] dir_z;
    logic signed [VecW-1:0] norm_x;
    logic signed [VecW-1:0] norm_y;
    logic signed [VecW-1:0] norm_z;
    logic [ChanW-1:0]       obj_red;
    logic [ChanW-1:0]       obj_green;
    logic [ChanW-1:0]       obj_blue;
  } dap_in_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
  } dap_out_t;

  // Data that rides along the chains unchanged
  typedef struct packed {
    logic             hit;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             dot_pos;
    logic [31:0]      dot_mag;
  } dap_side_t;

  typedef struct packed {
    logic [ProdW-1:0] x;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    dap_side_t        side;
  } dap_sqrt_t;

  typedef struct packed {
    logic [NumW-1:0]     num;
    logic [NumW-1:0]     den;
    logic [DivSteps-1:0] quo;
    logic                clamp;
    logic                ok;
    dap_side_t           side;
  } dap_div_t;

endpackage

/* sv/diffuse_ambient_pixel_shader_core.sv */
// Channel  | Ports                          | Carries
// input    | in_valid, in_stall, in_data    | hit flag, two vectors, object color
// result   | out_valid, out_stall, out_data | shaded color
// config   | cfg_we, cfg_index, cfg_wdata   | ambient, light power, background
//
// One pixel per clock while no result is held under out_stall; the pipeline has
// 50 register stages: dot product, root input, 32 square root cells,
// divider setup, 13 divider cells, light scaling and the output register.
// Reset clears all valid bits and loads the register reset values.
// A held result under out_stall freezes every stage and holds in_stall high.
module diffuse_ambient_pixel_shader_core
  import dap_shader_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dap_in_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dap_out_t           out_data,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [RegW-1:0]    cfg_wdata
);

  logic [RegW-1:0]  ambient_r;
  logic [RegW-1:0]  light_r;
  logic [ChanW-1:0] bg_red_r;
  logic [ChanW-1:0] bg_green_r;
  logic [ChanW-1:0] bg_blue_r;

  logic adv;

  logic signed [31:0] p_x, p_y, p_z;
  logic signed [33:0] dot_sum;
  logic [31:0]        dd_sum, nn_sum;

  logic        s0_valid_r;
  dap_side_t   s0_side_r;
  logic [31:0] s0_dd_r, s0_nn_r;

  logic      sq0_valid_r;
  dap_sqrt_t sq0_r;

  logic      sq_v [0:SqrtSteps];
  dap_sqrt_t sq_d [0:SqrtSteps];
  logic      dv_v [0:DivSteps];
  dap_div_t  dv_d [0:DivSteps];

  dap_div_t prep_nxt;
  logic     prep_valid_r;
  dap_div_t prep_r;

  logic [CosW-1:0]   cos_q;
  logic [28:0]       fac_prod;
  logic              fac_valid_r;
  logic [16:0]       fac_r;
  dap_side_t         fac_side_r;

  logic [17:0] gain;
  logic [25:0] prod_r, prod_g, prod_b;
  dap_out_t    res_nxt;
  logic        out_valid_r;
  dap_out_t    out_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ambient_r  <= 16'd4096;
      light_r    <= 16'd4096;
      bg_red_r   <= '0;
      bg_green_r <= '0;
      bg_blue_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegAmbient: ambient_r  <= cfg_wdata;
        RegLight:   light_r    <= cfg_wdata;
        RegBgRed:   bg_red_r   <= cfg_wdata[ChanW-1:0];
        RegBgGreen: bg_green_r <= cfg_wdata[ChanW-1:0];
        RegBgBlue:  bg_blue_r  <= cfg_wdata[ChanW-1:0];
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline unless a finished result is held
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Stage 0: dot product and squared lengths
  always_comb begin
    p_x = 32'(in_data.dir_x * in_data.norm_x);
    p_y = 32'(in_data.dir_y * in_data.norm_y);
    p_z = 32'(in_data.dir_z * in_data.norm_z);
    dot_sum = 34'(p_x) + 34'(p_y) + 34'(p_z);
    dd_sum = 32'(in_data.dir_x * in_data.dir_x) + 32'(in_data.dir_y * in_data.dir_y)
           + 32'(in_data.dir_z * in_data.dir_z);
    nn_sum = 32'(in_data.norm_x * in_data.norm_x) + 32'(in_data.norm_y * in_data.norm_y)
           + 32'(in_data.norm_z * in_data.norm_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_side_r.hit     <= in_data.hit;
      s0_side_r.red     <= in_data.obj_red;
      s0_side_r.green   <= in_data.obj_green;
      s0_side_r.blue    <= in_data.obj_blue;
      s0_side_r.dot_pos <= (dot_sum > 34'sd0);
      s0_side_r.dot_mag <= dot_sum[31:0];
      s0_dd_r           <= dd_sum;
      s0_nn_r           <= nn_sum;
    end
  end

  // Stage 1: product of squared lengths feeds the root chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq0_valid_r <= 1'b0;
    end else if (adv) begin
      sq0_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq0_r.x    <= ProdW'(s0_dd_r) * ProdW'(s0_nn_r);
      sq0_r.rem  <= '0;
      sq0_r.root <= '0;
      sq0_r.side <= s0_side_r;
    end
  end

  assign sq_v[0] = sq0_valid_r;
  assign sq_d[0] = sq0_r;

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    dap_sqrt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (adv),
      .prev_valid (sq_v[i]),
      .prev       (sq_d[i]),
      .cell_valid (sq_v[i+1]),
      .stage      (sq_d[i+1])
    );
  end

  // Set up the division and flag the clamp case
  always_comb begin
    prep_nxt.num   = {1'b0, sq_d[SqrtSteps].side.dot_mag, 12'd0};
    prep_nxt.den   = {1'b0, sq_d[SqrtSteps].root, 12'd0};
    prep_nxt.quo   = '0;
    prep_nxt.clamp = prep_nxt.num >= {sq_d[SqrtSteps].root, 13'd0};
    prep_nxt.ok    = sq_d[SqrtSteps].side.dot_pos && (sq_d[SqrtSteps].root != '0);
    prep_nxt.side  = sq_d[SqrtSteps].side;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_valid_r <= 1'b0;
    end else if (adv) begin
      prep_valid_r <= sq_v[SqrtSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prep_r <= prep_nxt;
    end
  end

  assign dv_v[0] = prep_valid_r;
  assign dv_d[0] = prep_r;

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    dap_div_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (adv),
      .prev_valid (dv_v[j]),
      .prev       (dv_d[j]),
      .cell_valid (dv_v[j+1]),
      .stage      (dv_d[j+1])
    );
  end

  // Clamp the cosine and scale it by light power
  always_comb begin
    if (!dv_d[DivSteps].ok) begin
      cos_q = '0;
    end else if (dv_d[DivSteps].clamp || (dv_d[DivSteps].quo > OneQ12)) begin
      cos_q = OneQ12;
    end else begin
      cos_q = dv_d[DivSteps].quo;
    end
    fac_prod = 29'(light_r) * 29'(cos_q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fac_valid_r <= 1'b0;
    end else if (adv) begin
      fac_valid_r <= dv_v[DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fac_r      <= fac_prod[28:12];
      fac_side_r <= dv_d[DivSteps].side;
    end
  end

  // Apply the gain per channel, saturate, or pick the background on a miss
  always_comb begin
    gain   = 18'(ambient_r) + 18'(fac_r);
    prod_r = 26'(fac_side_r.red) * 26'(gain);
    prod_g = 26'(fac_side_r.green) * 26'(gain);
    prod_b = 26'(fac_side_r.blue) * 26'(gain);
    if (!fac_side_r.hit) begin
      res_nxt.out_red   = bg_red_r;
      res_nxt.out_green = bg_green_r;
      res_nxt.out_blue  = bg_blue_r;
    end else begin
      res_nxt.out_red   = (prod_r[25:20] != '0) ? ChanMax : prod_r[19:12];
      res_nxt.out_green = (prod_g[25:20] != '0) ? ChanMax : prod_g[19:12];
      res_nxt.out_blue  = (prod_b[25:20] != '0) ? ChanMax : prod_b[19:12];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fac_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Frozen pipeline keeps its occupancy
  a_freeze_keeps_chain: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(prep_valid_r) && $stable(fac_valid_r) && $stable(sq_v[SqrtSteps]))
    else $error("pipeline occupancy changed while stalled");

  // Input is only held off by a held result
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall)
    else $error("input stalled without a held result");

  // Nothing leaves the pipeline right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid_r && !fac_valid_r)
    else $error("result valid right after reset");

endmodule

/* sv/dap_sqrt_cell.sv */
module dap_sqrt_cell
  import dap_shader_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      prev_valid,
  input  dap_sqrt_t prev,
  output logic      cell_valid,
  output dap_sqrt_t stage
);

  logic [RemW-1:0] rem_sh;
  logic [RemW-1:0] trial;
  dap_sqrt_t       cell_nxt;
  logic            valid_r;
  dap_sqrt_t       data_r;

  // Bring in the next two radicand bits and try the next root bit
  always_comb begin
    rem_sh = {prev.rem[RemW-3:0], prev.x[ProdW-1 -: 2]};
    trial  = {1'b0, prev.root, 2'b01};
    cell_nxt = prev;
    cell_nxt.x = {prev.x[ProdW-3:0], 2'b00};
    if (rem_sh >= trial) begin
      cell_nxt.rem  = rem_sh - trial;
      cell_nxt.root = {prev.root[RootW-2:0], 1'b1};
    end else begin
      cell_nxt.rem  = rem_sh;
      cell_nxt.root = {prev.root[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= cell_nxt;
    end
  end

  assign cell_valid = valid_r;
  assign stage      = data_r;

endmodule

/* sv/dap_div_cell.sv */
module dap_div_cell
  import dap_shader_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  logic     prev_valid,
  input  dap_div_t prev,
  output logic     cell_valid,
  output dap_div_t stage
);

  dap_div_t cell_nxt;
  logic     valid_r;
  dap_div_t data_r;

  // One restoring step: subtract the shifted divisor if it fits
  always_comb begin
    cell_nxt = prev;
    cell_nxt.den = {1'b0, prev.den[NumW-1:1]};
    if (prev.num >= prev.den) begin
      cell_nxt.num = prev.num - prev.den;
      cell_nxt.quo = {prev.quo[DivSteps-2:0], 1'b1};
    end else begin
      cell_nxt.quo = {prev.quo[DivSteps-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= cell_nxt;
    end
  end

  assign cell_valid = valid_r;
  assign stage      = data_r;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import dap_shader_pkg::*;

  // Holds the shading registers and the queue of expected pixel colors.
  class shade_board;
    logic [RegW-1:0]  ambient;
    logic [RegW-1:0]  light;
    logic [ChanW-1:0] bg_r, bg_g, bg_b;
    dap_out_t         pending_colors[$];
    int               mismatches;
    int               checked;

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [RegW-1:0] val);
      case (idx)
        RegAmbient: ambient = val;
        RegLight:   light = val;
        RegBgRed:   bg_r = val[ChanW-1:0];
        RegBgGreen: bg_g = val[ChanW-1:0];
        RegBgBlue:  bg_b = val[ChanW-1:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] root_floor(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x = x - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function logic [ChanW-1:0] scale_chan(logic [ChanW-1:0] c, logic [63:0] gain);
      logic [63:0] v;
      v = (64'(c) * gain) >> 12;
      return (v > 255) ? ChanMax : v[ChanW-1:0];
    endfunction

    // Predict the color of one accepted pixel.
    function void note_pixel(dap_in_t px);
      dap_out_t     col;
      longint       dotp;
      logic [63:0]  dd, nn, rt, cosq, gain;
      longint       d[3], n[3];
      d[0] = px.dir_x;  d[1] = px.dir_y;  d[2] = px.dir_z;
      n[0] = px.norm_x; n[1] = px.norm_y; n[2] = px.norm_z;
      if (!px.hit) begin
        col = '{bg_r, bg_g, bg_b};
      end else begin
        dotp = 0; dd = 0; nn = 0; cosq = 0;
        for (int i = 0; i < 3; i++) begin
          dotp += d[i] * n[i];
          dd += 64'(d[i] * d[i]);
          nn += 64'(n[i] * n[i]);
        end
        rt = root_floor(dd * nn);
        if (dotp > 0 && rt != 0) begin
          cosq = (64'(dotp) << 12) / rt;
          if (cosq > 4096) cosq = 4096;
        end
        gain = 64'(ambient) + ((64'(light) * cosq) >> 12);
        col.out_red   = scale_chan(px.obj_red, gain);
        col.out_green = scale_chan(px.obj_green, gain);
        col.out_blue  = scale_chan(px.obj_blue, gain);
      end
      pending_colors.push_back(col);
    endfunction

    // Compare one result transfer with the oldest prediction.
    function void check_color(dap_out_t got);
      dap_out_t want;
      checked++;
      if (pending_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending_colors.pop_front();
      if (want.out_red !== got.out_red || want.out_green !== got.out_green ||
          want.out_blue !== got.out_blue) begin
        mismatches++;
        if (mismatches <= 10)
          $display("color mismatch: expected %h actual %h", want, got);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  dap_in_t            in_data;
  logic               out_valid;
  logic               out_stall;
  dap_out_t           out_data;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [RegW-1:0]    cfg_wdata;

  shade_board board;
  int  cycle_count;
  int  hold_cycles;
  int  hit_count;
  bit  stall_enable;
  localparam int CycleLimit = 400000;

  diffuse_ambient_pixel_shader_core uut (.*);

  initial clk = 0;
  always #4 clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Note input transfers and check result transfers.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) board.note_pixel(in_data);
    if (rst_n && out_valid && !out_stall) board.check_color(out_data);
  end

  // Receiver stall pattern, plus long hold-offs on request.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (!stall_enable) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [RegW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one pixel and hold it until the transfer.
  task automatic send_pixel(dap_in_t px);
    in_valid <= 1'b1;
    in_data <= px;
    if (px.hit) hit_count++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  // Wait for every result, then let the pipeline drain.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_colors.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic logic [VecW-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic dap_in_t rand_pixel();
    dap_in_t px;
    px.hit = ($urandom_range(0, 4) != 0);
    px.dir_x = rand_comp();  px.dir_y = rand_comp();  px.dir_z = rand_comp();
    px.norm_x = rand_comp(); px.norm_y = rand_comp(); px.norm_z = rand_comp();
    // Often point the normal along the ray, so the cosine is large.
    if ($urandom_range(0, 2) == 0) begin
      px.norm_x = px.dir_x + 16'($urandom_range(0, 15));
      px.norm_y = px.dir_y;
      px.norm_z = px.dir_z;
    end
    px.obj_red = 8'($urandom);
    px.obj_green = 8'($urandom);
    px.obj_blue = 8'($urandom);
    return px;
  endfunction

  function automatic dap_in_t make_pixel(logic h, logic [VecW-1:0] dx, dy, dz, nx, ny, nz,
                                         logic [ChanW-1:0] c);
    return '{h, dx, dy, dz, nx, ny, nz, c, ~c, c ^ 8'h5a};
  endfunction

  task automatic directed_pixels();
    send_pixel(make_pixel(0, 16'h1234, 0, 0, 16'h1234, 0, 0, 8'hff));
    send_pixel(make_pixel(1, 16'h1000, 0, 0, 16'h1000, 0, 0, 8'hff));
    send_pixel(make_pixel(1, 16'h7fff, 16'h7fff, 16'h7fff,
                          16'h7fff, 16'h7fff, 16'h7fff, 8'hff));
    send_pixel(make_pixel(1, 16'h8000, 16'h8000, 16'h8000,
                          16'h8000, 16'h8000, 16'h8000, 8'h80));
    send_pixel(make_pixel(1, 16'h8000, 0, 0, 16'h7fff, 0, 0, 8'hc0));
    send_pixel(make_pixel(1, 0, 0, 0, 16'h0100, 0, 0, 8'hff));
    send_pixel(make_pixel(1, 16'h0100, 0, 0, 0, 0, 0, 8'h40));
    send_pixel(make_pixel(1, 16'h0100, 0, 0, 0, 16'h0100, 0, 8'h7f));
    send_pixel(make_pixel(1, 16'h0003, 16'h0001, 0, 16'h0003, 16'h0001, 0, 8'hff));
    send_pixel(make_pixel(1, 1, 1, 1, 1, 1, 1, 8'h01));
    send_pixel(make_pixel(1, 16'hffff, 16'h0002, 16'h7fff,
                          16'hffff, 16'h0002, 16'h7ffe, 8'h00));
    send_pixel(make_pixel(0, 16'h8000, 16'h7fff, 0, 0, 0, 0, 8'h00));
  endtask

  task automatic random_pixels(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && count > 0) begin
        send_pixel(rand_pixel());
        burst--;
        count--;
      end
      if ($urandom_range(0, 2) != 0) pause_sender();
    end
  endtask

  initial begin
    board = new();
    board.ambient = 16'd4096; board.light = 16'd4096;
    board.bg_r = 0; board.bg_g = 0; board.bg_b = 0;
    board.mismatches = 0; board.checked = 0;
    cycle_count = 0; hold_cycles = 0; hit_count = 0; stall_enable = 0;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset register values first.
    directed_pixels();
    drain();

    // Extremes of ambient, light and background red and green, plus an ignored index.
    write_reg(RegAmbient, 16'hffff);
    write_reg(RegLight, 16'hffff);
    write_reg(RegBgRed, 16'h00ff);
    write_reg(RegBgGreen, 16'h0000);
    write_reg(RegBgBlue, 16'h00a5);
    write_reg(3'd7, 16'h1234);
    stall_enable = 1;
    directed_pixels();
    random_pixels(60);
    drain();

    write_reg(RegAmbient, 16'h0000);
    write_reg(RegLight, 16'h0000);
    write_reg(RegBgRed, 16'h0000);
    write_reg(RegBgGreen, 16'h00ff);
    write_reg(RegBgBlue, 16'h005a);
    random_pixels(60);
    drain();

    // Long receiver hold-off while the sender keeps going.
    write_reg(RegAmbient, 16'h0800);
    write_reg(RegLight, 16'h1000);
    hold_cycles = 200;
    random_pixels(100);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      write_reg(RegAmbient, 16'($urandom_range(0, 16'h2000)));
      write_reg(RegLight, 16'($urandom));
      write_reg(RegBgRed, 16'($urandom));
      write_reg(RegBgGreen, 16'($urandom));
      write_reg(RegBgBlue, 16'($urandom));
      stall_enable = (phase != 1);
      random_pixels(55);
    drain();
    end

    $display("covered %0d result checks, %0d hit pixels, register extremes and a long hold-off",
             board.checked, hit_count);
    if (board.mismatches == 0 && board.pending_colors.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
